// ----- rtl/shi_pkg.sv -----
`timescale 1ns / 1ps
package shi_pkg;

   localparam int ENTITY_COUNT_DEF  = 16;
   localparam int HISTORY_DEPTH_DEF = 11;
   localparam logic [15:0] RESET_DELAY = 16'd250;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_RENDER_DELAY = 3'd0;

   // result status codes
   typedef enum logic [1:0] {
      STAT_INTERP = 2'd0,
      STAT_SINGLE = 2'd1,
      STAT_EMPTY  = 2'd2,
      STAT_EQUAL  = 2'd3
   } status_type;

   // commands from controller to datapath
   typedef struct packed {
      logic take;
      logic rec_write;
      logic rd_first;
      logic rd_k;
      logic rd_prev;
      logic k_incr;
      logic latch_l;
      logic latch_p;
      logic ld_coord;
      logic mul_step;
      logic div_init;
      logic div_step;
      logic acc_step;
      logic set_empty;
      logic set_single;
      logic set_equal;
      logic finish;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic req_valid;
      logic is_query;
      logic fill_zero;
      logic fill_one;
      logic search_more;
      logic den_zero;
      logic mul_done;
      logic div_done;
      logic coord_last;
      logic out_free;
   } stat_type;

endpackage

// ----- rtl/shi_req_if.sv -----
`timescale 1ns / 1ps
interface shi_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [3:0]         entity;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] heading;
   logic [31:0]        stamp;

   modport source (output valid, mode, entity, pos_x, pos_y, heading, stamp, input ready);
   modport sink (input valid, mode, entity, pos_x, pos_y, heading, stamp, output ready);
endinterface

// ----- rtl/shi_rsp_if.sv -----
`timescale 1ns / 1ps
interface shi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_heading;
   logic [1:0]         status;

   modport source (output valid, out_x, out_y, out_heading, status, input ready);
   modport sink (input valid, out_x, out_y, out_heading, status, output ready);
endinterface

// ----- rtl/shi_ctrl.sv -----
`timescale 1ns / 1ps
module shi_ctrl import shi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_DECODE   = 13'b0000000000010,
      S_SINGLE   = 13'b0000000000100,
      S_SRCH_RD  = 13'b0000000001000,
      S_SRCH_CHK = 13'b0000000010000,
      S_PREV     = 13'b0000000100000,
      S_LOAD     = 13'b0000001000000,
      S_MUL      = 13'b0000010000000,
      S_DIV_INIT = 13'b0000100000000,
      S_DIV      = 13'b0001000000000,
      S_ACC      = 13'b0010000000000,
      S_FINISH   = 13'b0100000000000,
      S_SPARE    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take = 1'b1;
            if (stat.req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            priority if (!stat.is_query) begin
               cmd.rec_write = 1'b1;
               state_in = S_IDLE;
            end else if (stat.fill_zero) begin
               cmd.set_empty = 1'b1;
               state_in = S_FINISH;
            end else if (stat.fill_one) begin
               cmd.rd_first = 1'b1;
               state_in = S_SINGLE;
            end else begin
               cmd.rd_k = 1'b1;
               state_in = S_SRCH_CHK;
            end
         end
         S_SINGLE: begin
            cmd.set_single = 1'b1;
            state_in = S_FINISH;
         end
         S_SRCH_RD: begin
            cmd.rd_k = 1'b1;
            state_in = S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            if (stat.search_more) begin
               cmd.k_incr = 1'b1;
               state_in = S_SRCH_RD;
            end else begin
               cmd.latch_l = 1'b1;
               cmd.rd_prev = 1'b1;
               state_in = S_PREV;
            end
         end
         S_PREV: begin
            cmd.latch_p = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (stat.den_zero) begin
               cmd.set_equal = 1'b1;
               state_in = S_FINISH;
            end else begin
               cmd.ld_coord = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (stat.mul_done) state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc_step = 1'b1;
            state_in = stat.coord_last ? S_FINISH : S_LOAD;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ----- rtl/shi_dp.sv -----
`timescale 1ns / 1ps
module shi_dp import shi_pkg::*; #(
   parameter int ENTITY_COUNT  = ENTITY_COUNT_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   shi_req_if.sink               req_ch,
   shi_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   input  cmd_type               cmd,
   output stat_type              stat
);

   localparam int CW  = $clog2(HISTORY_DEPTH + 1);
   localparam int HW  = $clog2(HISTORY_DEPTH);
   localparam int EIW = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
   localparam int MD  = ENTITY_COUNT * HISTORY_DEPTH;
   localparam int AW  = $clog2(MD);
   localparam logic [1:0] COORD_LAST = 2'd2;

   // wrap an offset from the oldest slot into the ring
   function automatic logic [HW-1:0] ring_pos(input logic [HW-1:0] oldest,
                                              input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(oldest) + (CW+1)'(off);
      if (sum >= (CW+1)'(HISTORY_DEPTH)) sum = sum - (CW+1)'(HISTORY_DEPTH);
      return sum[HW-1:0];
   endfunction

   // configuration register
   logic [15:0] delay_ff;
   always_ff @(posedge clock) begin
      if (reset) delay_ff <= RESET_DELAY;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_RENDER_DELAY)
         delay_ff <= csr_pwdata[15:0];
   end
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_RENDER_DELAY) ? {16'd0, delay_ff} : '0;

   // latched item
   logic               accept;
   logic               mode_ff, ent_ok_ff;
   logic [EIW-1:0]     ent_ff;
   logic signed [31:0] in_x_ff, in_y_ff, in_h_ff;
   logic [31:0]        stamp_ff, now_ff;

   assign req_ch.ready = cmd.take;
   assign accept = cmd.take && req_ch.valid;

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_ch.mode;
         ent_ok_ff <= int'(req_ch.entity) < ENTITY_COUNT;
         ent_ff    <= EIW'(req_ch.entity);
         in_x_ff   <= req_ch.pos_x;
         in_y_ff   <= req_ch.pos_y;
         in_h_ff   <= req_ch.heading;
         stamp_ff  <= req_ch.stamp;
         now_ff    <= req_ch.stamp - {16'd0, delay_ff};
      end
   end

   // per-entity ring bookkeeping
   logic [CW-1:0] fill_tab_ff [ENTITY_COUNT];
   logic [HW-1:0] old_tab_ff [ENTITY_COUNT];
   logic [CW-1:0] fill_cur;
   logic [HW-1:0] old_cur;
   logic [EIW-1:0] ent_idx;
   logic          full;

   assign ent_idx  = ent_ok_ff ? ent_ff : '0;
   assign fill_cur = ent_ok_ff ? fill_tab_ff[ent_idx] : '0;
   assign old_cur  = old_tab_ff[ent_idx];
   assign full     = fill_cur >= CW'(HISTORY_DEPTH);

   logic write_rec;
   assign write_rec = cmd.rec_write && ent_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTITY_COUNT; i++) begin
            fill_tab_ff[i] <= '0;
            old_tab_ff[i]  <= '0;
         end
      end else if (write_rec) begin
         if (full) old_tab_ff[ent_idx] <= ring_pos(old_cur, CW'(1));
         else fill_tab_ff[ent_idx] <= fill_cur + CW'(1);
      end
   end

   // search index
   logic [CW-1:0] k_ff;
   always_ff @(posedge clock) begin
      if (accept) k_ff <= CW'(1);
      else if (cmd.k_incr) k_ff <= k_ff + CW'(1);
   end

   // snapshot memory: x, y, heading, time
   logic [127:0]  mem [MD];
   logic [127:0]  rd_ff;
   logic [AW-1:0] base, wr_addr, rd_addr;
   logic [CW-1:0] rd_off;
   logic [HW-1:0] wr_pos;

   assign base    = AW'(ent_idx) * AW'(HISTORY_DEPTH);
   assign wr_pos  = full ? old_cur : ring_pos(old_cur, fill_cur);
   assign wr_addr = base + AW'(wr_pos);

   always_comb begin
      priority if (cmd.rd_first) rd_off = '0;
      else if (cmd.rd_prev) rd_off = k_ff - CW'(1);
      else rd_off = k_ff;
   end
   assign rd_addr = base + AW'(ring_pos(old_cur, rd_off));

   always_ff @(posedge clock) begin
      if (write_rec) mem[wr_addr] <= {in_x_ff, in_y_ff, in_h_ff, stamp_ff};
      if (cmd.rd_first || cmd.rd_k || cmd.rd_prev) rd_ff <= mem[rd_addr];
   end

   logic [31:0] rd_t;
   assign rd_t = rd_ff[31:0];

   // bracketing snapshots
   logic [127:0] l_ff, p_ff;
   always_ff @(posedge clock) begin
      if (cmd.latch_l) l_ff <= rd_ff;
      if (cmd.latch_p) p_ff <= rd_ff;
   end

   logic [31:0] num, den, den_mag;
   assign num     = now_ff - p_ff[31:0];
   assign den     = l_ff[31:0] - p_ff[31:0];
   assign den_mag = den[31] ? (32'd0 - den) : den;

   // coordinate select
   logic [1:0]  coord_ff;
   logic [31:0] p_c, l_c;
   always_comb begin
      unique case (coord_ff)
         2'd0: begin p_c = p_ff[127:96]; l_c = l_ff[127:96]; end
         2'd1: begin p_c = p_ff[95:64];  l_c = l_ff[95:64];  end
         default: begin p_c = p_ff[63:32]; l_c = l_ff[63:32]; end
      endcase
   end

   // serial multiply then divide
   logic [63:0] mcand_ff, prod_ff;
   logic [31:0] mplier_ff, rem_ff;
   logic [5:0]  cnt_ff;
   logic        neg_ff;
   logic [32:0] diff, diff_mag, rem_sh;
   logic        ge;

   assign diff     = {l_c[31], l_c} - {p_c[31], p_c};
   assign diff_mag = diff[32] ? (33'd0 - diff) : diff;
   assign rem_sh   = {rem_ff, prod_ff[63]};
   assign ge       = rem_sh >= {1'b0, den_mag};

   always_ff @(posedge clock) begin
      if (cmd.latch_p) coord_ff <= '0;
      else if (cmd.acc_step) coord_ff <= coord_ff + 2'd1;
      if (cmd.ld_coord) begin
         mcand_ff  <= {31'd0, diff_mag};
         mplier_ff <= num[31] ? (32'd0 - num) : num;
         neg_ff    <= diff[32] ^ num[31] ^ den[31];
         prod_ff   <= '0;
         cnt_ff    <= '0;
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) prod_ff <= prod_ff + mcand_ff;
         mcand_ff  <= {mcand_ff[62:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[31:1]};
         cnt_ff    <= cnt_ff + 6'd1;
      end else if (cmd.div_init) begin
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? 32'(rem_sh - {1'b0, den_mag}) : rem_sh[31:0];
         prod_ff <= {prod_ff[62:0], ge};
         cnt_ff  <= cnt_ff + 6'd1;
      end
   end

   // add to the earlier value and saturate
   logic [63:0] q_s;
   logic [64:0] sum;
   logic [31:0] sat;
   assign q_s = neg_ff ? (64'd0 - prod_ff) : prod_ff;
   assign sum = {{33{p_c[31]}}, p_c} + {q_s[63], q_s};
   always_comb begin
      if (sum[64:31] == '0 || sum[64:31] == '1) sat = sum[31:0];
      else if (sum[64]) sat = 32'h8000_0000;
      else sat = 32'h7FFF_FFFF;
   end

   // result staging
   logic [31:0] res_x_ff, res_y_ff, res_h_ff;
   status_type  res_st_ff;
   always_ff @(posedge clock) begin
      priority if (cmd.set_empty || cmd.set_equal) begin
         res_x_ff  <= '0;
         res_y_ff  <= '0;
         res_h_ff  <= '0;
         res_st_ff <= cmd.set_empty ? STAT_EMPTY : STAT_EQUAL;
      end else if (cmd.set_single) begin
         res_x_ff  <= rd_ff[127:96];
         res_y_ff  <= rd_ff[95:64];
         res_h_ff  <= rd_ff[63:32];
         res_st_ff <= STAT_SINGLE;
      end else if (cmd.acc_step) begin
         unique case (coord_ff)
            2'd0: res_x_ff <= sat;
            2'd1: res_y_ff <= sat;
            default: res_h_ff <= sat;
         endcase
         res_st_ff <= STAT_INTERP;
      end
   end

   // output register
   logic               rsp_valid_ff;
   logic signed [31:0] out_x_ff, out_y_ff, out_h_ff;
   logic [1:0]         out_st_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.finish) rsp_valid_ff <= 1'b1;
      else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_x_ff  <= res_x_ff;
         out_y_ff  <= res_y_ff;
         out_h_ff  <= res_h_ff;
         out_st_ff <= res_st_ff;
      end
   end
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_x       = out_x_ff;
   assign rsp_ch.out_y       = out_y_ff;
   assign rsp_ch.out_heading = out_h_ff;
   assign rsp_ch.status      = out_st_ff;

   // status to controller
   always_comb begin
      stat.req_valid   = req_ch.valid;
      stat.is_query    = mode_ff;
      stat.fill_zero   = fill_cur == '0;
      stat.fill_one    = fill_cur == CW'(1);
      stat.search_more = (k_ff < fill_cur - CW'(1)) && (now_ff > rd_t);
      stat.den_zero    = den == '0;
      stat.mul_done    = cnt_ff == 6'd31;
      stat.div_done    = cnt_ff == 6'd63;
      stat.coord_last  = coord_ff == COORD_LAST;
      stat.out_free    = !rsp_valid_ff || rsp_ch.ready;
   end

endmodule

// ----- rtl/snapshot_history_interpolator.sv -----
`timescale 1ns / 1ps
// Per-entity snapshot history with linear interpolation. A record transfer
// (mode 0) stores a timed pose in the entity's ring, dropping the oldest once
// the ring is full, and gives no result. A query transfer (mode 1) returns
// one result. An empty history or a single snapshot needs no search;
// otherwise k snapshots are scanned (up to HISTORY_DEPTH-1, one registered
// memory read each), and unless the bracketing times are equal each of the
// three coordinates runs 32 steps of a shift-add multiplier and 64 steps of
// a restoring divider that all coordinates share. One item is in work at a
// time; a finished result waits in the output register while the next item
// is taken, and a query stalls in its last cycle while that register is
// still full and not being read. render_delay sits at address 0 of the csr
// port.
module snapshot_history_interpolator import shi_pkg::*; #(
   parameter int ENTITY_COUNT  = ENTITY_COUNT_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   shi_req_if.sink               req_ch,
   shi_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cmd_type  cmd;
   stat_type stat;

   shi_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   shi_dp #(
      .ENTITY_COUNT  (ENTITY_COUNT),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule
